>>> rtl/png_unfilter_rgb24_unit_defines.svh
// Assertion macros shared by the unfilter design files.
`ifndef PNG_UNFILTER_RGB24_UNIT_DEFINES_SVH
`define PNG_UNFILTER_RGB24_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNGU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNGU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/pngu_pkg.sv
package pngu_pkg;

  localparam int unsigned MAX_ROW_BYTES = 4096;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned ROW_BYTES_W   = 13;
  localparam int unsigned IMAGE_ROWS_W  = 16;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned OUTQ_DEPTH    = 3;
  localparam int unsigned ROW_BYTES_RST = 3;
  localparam int unsigned IMAGE_ROWS_RST = 1;
  localparam int unsigned PIXEL_BYTES   = 3;

  typedef enum logic [0:0] {
    REG_ROW_BYTES  = 1'b0,
    REG_IMAGE_ROWS = 1'b1
  } cfg_reg_e;

  typedef enum logic [7:0] {
    FILT_NONE  = 8'd0,
    FILT_SUB   = 8'd1,
    FILT_UP    = 8'd2,
    FILT_AVG   = 8'd3,
    FILT_PAETH = 8'd4
  } filter_e;

  // Sample byte on its way from the input to the reconstruction stage.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first_row;
    logic              row_start;
    logic              row_end;
    logic              image_end;
  } ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              row_end;
    logic              image_end;
  } res_t;

endpackage

>>> rtl/png_unfilter_rgb24_unit.sv
// Channel | Direction | Signals
// in      | sink      | in_valid_i, in_ready_o, data_byte_i
// out     | source    | out_valid_o, out_ready_i, pixel_byte_o, row_end_o, image_end_o
// cfg     | sink      | cfg_we_i, cfg_addr_i, cfg_wdata_i (write only, no wait)
//
// One input transaction per cycle is taken when the output side keeps up.
// A sample byte reads the line buffer at acceptance and is reconstructed in the next cycle,
// when its result is written back and queued; the result then leaves from the output queue.
// A three-entry output queue absorbs output stalls.
// Reset clears all control state; the line buffer is not cleared.
`include "png_unfilter_rgb24_unit_defines.svh"

module png_unfilter_rgb24_unit #(
  parameter int unsigned MaxRowBytes = pngu_pkg::MAX_ROW_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pngu_pkg::BYTE_W-1:0]      data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pngu_pkg::BYTE_W-1:0]      pixel_byte_o,
  output logic                             row_end_o,
  output logic                             image_end_o,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_addr_i,
  input  logic [pngu_pkg::CFG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(MaxRowBytes);
  localparam int unsigned CW   = $clog2(MaxRowBytes + 1);
  localparam int unsigned CMPW = (CW > pngu_pkg::ROW_BYTES_W) ? CW : pngu_pkg::ROW_BYTES_W;
  localparam int unsigned RW   = pngu_pkg::IMAGE_ROWS_W;
  localparam int unsigned NW   = $clog2(pngu_pkg::OUTQ_DEPTH + 1);

  logic [pngu_pkg::ROW_BYTES_W-1:0] row_bytes_q;
  logic [RW-1:0]                    image_rows_q;
  logic [pngu_pkg::BYTE_W-1:0]      filter_q;
  logic [CW-1:0]                    col_q;
  logic [RW-1:0]                    row_q;
  logic                             s1_valid_q;
  pngu_pkg::ctl_t                   s1_ctl_q;
  logic [AW-1:0]                    s1_addr_q;

  logic [CMPW-1:0]             rb_ext;
  logic [CW-1:0]               eff_rb, pos;
  logic [RW-1:0]               eff_rows;
  logic                        awaiting, in_acc, row_end, last_row;
  logic [pngu_pkg::BYTE_W-1:0] above;
  pngu_pkg::res_t              res, q_res;
  logic [NW-1:0]               q_count;
  logic [NW:0]                 occupancy;

  always_comb begin
    rb_ext = CMPW'(row_bytes_q);
    if (rb_ext < CMPW'(pngu_pkg::ROW_BYTES_RST)) begin
      eff_rb = CW'(pngu_pkg::ROW_BYTES_RST);
    end else if (rb_ext > CMPW'(MaxRowBytes)) begin
      eff_rb = CW'(MaxRowBytes);
    end else begin
      eff_rb = rb_ext[CW-1:0];
    end
    eff_rows = (image_rows_q == '0) ? RW'(1) : image_rows_q;
  end

  assign awaiting  = (col_q == '0);
  assign pos       = col_q - CW'(1);
  assign row_end   = (col_q >= eff_rb);
  assign last_row  = (({1'b0, row_q} + (RW+1)'(1)) >= {1'b0, eff_rows});
  assign occupancy = (NW+1)'(q_count) + (NW+1)'(s1_valid_q);
  assign in_ready_o = (occupancy < (NW+1)'(pngu_pkg::OUTQ_DEPTH));
  assign in_acc    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q  <= pngu_pkg::ROW_BYTES_W'(pngu_pkg::ROW_BYTES_RST);
      image_rows_q <= RW'(pngu_pkg::IMAGE_ROWS_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pngu_pkg::REG_ROW_BYTES:  row_bytes_q  <= cfg_wdata_i[pngu_pkg::ROW_BYTES_W-1:0];
        pngu_pkg::REG_IMAGE_ROWS: image_rows_q <= cfg_wdata_i[RW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q   <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc && !awaiting;
      if (in_acc) begin
        if (awaiting) begin
          filter_q <= data_byte_i;
          col_q    <= CW'(1);
        end else if (row_end) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !awaiting) begin
      s1_ctl_q.data      <= data_byte_i;
      s1_ctl_q.first_row <= (row_q == '0);
      s1_ctl_q.row_start <= (pos < CW'(pngu_pkg::PIXEL_BYTES));
      s1_ctl_q.row_end   <= row_end;
      s1_ctl_q.image_end <= row_end && last_row;
      s1_addr_q          <= pos[AW-1:0];
    end
  end

  pngu_ram #(
    .Width(pngu_pkg::BYTE_W),
    .Depth(MaxRowBytes)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (res.pixel),
    .re_i    (in_acc && !awaiting),
    .raddr_i (pos[AW-1:0]),
    .rdata_o (above)
  );

  pngu_recon u_recon (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .ctl_i    (s1_ctl_q),
    .filter_i (filter_q),
    .above_i  (above),
    .res_o    (res)
  );

  pngu_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .res_i   (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (q_res),
    .count_o (q_count)
  );

  assign pixel_byte_o = q_res.pixel;
  assign row_end_o    = q_res.row_end;
  assign image_end_o  = q_res.image_end;

  `PNGU_ASSERT_NEXT(a_sample_enters_stage, in_acc && !awaiting, s1_valid_q, "sample transaction did not reach the reconstruction stage")
  `PNGU_ASSERT_NEXT(a_filter_gives_nothing, in_acc && awaiting, !s1_valid_q, "filter byte produced a result")
  `PNGU_ASSERT_NOW(a_image_end_ends_row, out_valid_o && image_end_o, row_end_o, "image end without row end")

endmodule

>>> rtl/pngu_ram.sv
module pngu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pngu_recon.sv
module pngu_recon (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  pngu_pkg::ctl_t                ctl_i,
  input  logic [pngu_pkg::BYTE_W-1:0]   filter_i,
  input  logic [pngu_pkg::BYTE_W-1:0]   above_i,
  output pngu_pkg::res_t                res_o
);

  // Reconstructed bytes and bytes from above of the last three samples.
  logic [pngu_pkg::BYTE_W-1:0] left_q [pngu_pkg::PIXEL_BYTES];
  logic [pngu_pkg::BYTE_W-1:0] upl_q  [pngu_pkg::PIXEL_BYTES];
  logic [pngu_pkg::BYTE_W-1:0] a, b, c, pred, pixel;
  logic [pngu_pkg::BYTE_W-1:0] pa, pb;
  logic [pngu_pkg::BYTE_W:0]   pc, sab, c2, avg_sum;

  always_comb begin
    a       = ctl_i.row_start ? '0 : left_q[pngu_pkg::PIXEL_BYTES-1];
    c       = ctl_i.row_start ? '0 : upl_q[pngu_pkg::PIXEL_BYTES-1];
    b       = ctl_i.first_row ? '0 : above_i;
    pa      = (b >= c) ? (b - c) : (c - b);
    pb      = (a >= c) ? (a - c) : (c - a);
    sab     = {1'b0, a} + {1'b0, b};
    c2      = {c, 1'b0};
    pc      = (sab >= c2) ? (sab - c2) : (c2 - sab);
    avg_sum = sab >> 1;
    case (filter_i)
      pngu_pkg::FILT_SUB:   pred = a;
      pngu_pkg::FILT_UP:    pred = b;
      pngu_pkg::FILT_AVG:   pred = avg_sum[pngu_pkg::BYTE_W-1:0];
      pngu_pkg::FILT_PAETH: begin
        if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
          pred = a;
        end else if ({1'b0, pb} <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:              pred = '0;
    endcase
    pixel = ctl_i.data + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pngu_pkg::PIXEL_BYTES; i++) begin
        left_q[i] <= '0;
        upl_q[i]  <= '0;
      end
    end else if (valid_i) begin
      left_q[0] <= pixel;
      upl_q[0]  <= b;
      for (int i = 1; i < pngu_pkg::PIXEL_BYTES; i++) begin
        left_q[i] <= left_q[i-1];
        upl_q[i]  <= upl_q[i-1];
      end
    end
  end

  assign res_o.pixel     = pixel;
  assign res_o.row_end   = ctl_i.row_end;
  assign res_o.image_end = ctl_i.image_end;

endmodule

>>> rtl/pngu_outq.sv
`include "png_unfilter_rgb24_unit_defines.svh"

module pngu_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pngu_pkg::res_t res_i,
  output logic           valid_o,
  input  logic           ready_i,
  output pngu_pkg::res_t res_o,
  output logic [$clog2(pngu_pkg::OUTQ_DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(pngu_pkg::OUTQ_DEPTH);
  localparam int unsigned NW = $clog2(pngu_pkg::OUTQ_DEPTH + 1);

  pngu_pkg::res_t mem_q [pngu_pkg::OUTQ_DEPTH];
  logic [PW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]  count_q, count_d;
  logic           pop;

  assign pop = valid_o && ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(pngu_pkg::OUTQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(pngu_pkg::OUTQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= res_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign res_o   = mem_q[rptr_q];
  assign count_o = count_q;

  `PNGU_ASSERT_NOW(a_no_overflow, push_i && !pop, count_q < NW'(pngu_pkg::OUTQ_DEPTH), "output queue overflow")
  `PNGU_ASSERT_NEXT(a_count_tracks, push_i && !pop, count_q != '0, "output queue count lost a transaction")

endmodule

>>> tb/sv/tb_png_unfilter_rgb24_unit.sv
`timescale 1ns / 1ps

module tb_png_unfilter_rgb24_unit;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 1850;
  localparam int unsigned SETTLE_CYCLES = 8;

  class unfilter_scoreboard;
    logic [7:0]  above_row [pngu_pkg::MAX_ROW_BYTES];
    logic [7:0]  left_px [pngu_pkg::PIXEL_BYTES];
    logic [7:0]  upleft_px [pngu_pkg::PIXEL_BYTES];
    logic [7:0]  filt;
    int unsigned col_idx;
    int unsigned row_idx;
    logic [12:0] row_len_cfg;
    logic [15:0] rows_cfg;
    int unsigned line_fill;
    pngu_pkg::res_t expected_pixels [$];
    int unsigned errors;
    int unsigned n_bytes;
    int unsigned n_checked;
    int unsigned rows_done;
    int unsigned images_done;
    int unsigned rows_by_filter [0:pngu_pkg::FILT_PAETH];
    int unsigned unknown_filter_rows;

    function new();
      for (int i = 0; i < pngu_pkg::PIXEL_BYTES; i++) begin
        left_px[i] = '0;
        upleft_px[i] = '0;
      end
      for (int i = 0; i <= pngu_pkg::FILT_PAETH; i++) begin
        rows_by_filter[i] = 0;
      end
      filt = pngu_pkg::FILT_NONE;
      col_idx = 0;
      row_idx = 0;
      row_len_cfg = 13'(pngu_pkg::ROW_BYTES_RST);
      rows_cfg = 16'(pngu_pkg::IMAGE_ROWS_RST);
      line_fill = 0;
      errors = 0;
      n_bytes = 0;
      n_checked = 0;
      rows_done = 0;
      images_done = 0;
      unknown_filter_rows = 0;
    endfunction

    function void set_reg(pngu_pkg::cfg_reg_e idx, logic [15:0] value);
      if (idx == pngu_pkg::REG_ROW_BYTES) begin
        row_len_cfg = value[12:0];
      end else begin
        rows_cfg = value;
      end
    endfunction

    function int unsigned eff_row_len();
      if (row_len_cfg < pngu_pkg::PIXEL_BYTES) return pngu_pkg::PIXEL_BYTES;
      if (row_len_cfg > pngu_pkg::MAX_ROW_BYTES) return pngu_pkg::MAX_ROW_BYTES;
      return row_len_cfg;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int pa;
      int pb;
      int pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    function void take_stream_byte(logic [7:0] x);
      int unsigned j;
      int unsigned lane;
      int unsigned row_len;
      int unsigned img_rows;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  pred;
      logic [8:0]  sum9;
      pngu_pkg::res_t res;
      n_bytes++;
      row_len = eff_row_len();
      if (col_idx == 0) begin
        filt = x;
        col_idx = 1;
        if (x > pngu_pkg::FILT_PAETH) unknown_filter_rows++;
        else rows_by_filter[x]++;
        return;
      end
      j = col_idx - 1;
      if (j >= pngu_pkg::MAX_ROW_BYTES) j = pngu_pkg::MAX_ROW_BYTES - 1;
      lane = j % pngu_pkg::PIXEL_BYTES;
      a = (j < pngu_pkg::PIXEL_BYTES) ? 8'h00 : left_px[lane];
      b = (row_idx == 0) ? 8'h00 : above_row[j];
      c = (j < pngu_pkg::PIXEL_BYTES) ? 8'h00 : upleft_px[lane];
      case (filt)
        pngu_pkg::FILT_SUB:   pred = a;
        pngu_pkg::FILT_UP:    pred = b;
        pngu_pkg::FILT_AVG: begin
          sum9 = {1'b0, a} + {1'b0, b};
          pred = sum9[8:1];
        end
        pngu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
        default:              pred = 8'h00;
      endcase
      res.pixel = x + pred;
      res.row_end = 1'b0;
      res.image_end = 1'b0;
      upleft_px[lane] = b;
      left_px[lane] = res.pixel;
      above_row[j] = res.pixel;
      if (j + 1 > line_fill) line_fill = j + 1;
      if (col_idx >= row_len) begin
        res.row_end = 1'b1;
        col_idx = 0;
        rows_done++;
        img_rows = (rows_cfg == 0) ? 1 : rows_cfg;
        if (row_idx + 1 >= img_rows) begin
          row_idx = 0;
          res.image_end = 1'b1;
          images_done++;
        end else begin
          row_idx++;
        end
      end else begin
        col_idx++;
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_pixel(logic [7:0] px, logic re, logic ie);
      pngu_pkg::res_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, pixel_byte %h row_end %b image_end %b",
                 $time, px, re, ie);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      n_checked++;
      if (px !== want.pixel) begin
        $display("%0t: pixel_byte expected %h actual %h", $time, want.pixel, px);
        errors++;
      end
      if (re !== want.row_end) begin
        $display("%0t: row_end expected %b actual %b", $time, want.row_end, re);
        errors++;
      end
      if (ie !== want.image_end) begin
        $display("%0t: image_end expected %b actual %b", $time, want.image_end, ie);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [pngu_pkg::BYTE_W-1:0] data_byte_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [pngu_pkg::BYTE_W-1:0] pixel_byte_o;
  logic                        row_end_o;
  logic                        image_end_o;
  logic                        cfg_we_i = 1'b0;
  logic [0:0]                  cfg_addr_i = pngu_pkg::REG_ROW_BYTES;
  logic [pngu_pkg::CFG_W-1:0]  cfg_wdata_i = '0;

  unfilter_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  extreme_vals [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};

  png_unfilter_rgb24_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_byte_o (pixel_byte_o),
    .row_end_o    (row_end_o),
    .image_end_o  (image_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pixel(pixel_byte_o, row_end_o, image_end_o);
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drive_byte(input logic [7:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_stream_byte(value);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [12:0] len, input logic [15:0] nrows);
    logic [15:0] len_word;
    len_word = {3'($urandom), len};
    cfg_we_i <= 1'b1;
    cfg_addr_i <= pngu_pkg::REG_ROW_BYTES;
    cfg_wdata_i <= len_word;
    @(posedge clk_i);
    sb.set_reg(pngu_pkg::REG_ROW_BYTES, len_word);
    cfg_addr_i <= pngu_pkg::REG_IMAGE_ROWS;
    cfg_wdata_i <= nrows;
    @(posedge clk_i);
    sb.set_reg(pngu_pkg::REG_IMAGE_ROWS, nrows);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    if (sb.col_idx == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        return 8'($urandom_range(pngu_pkg::FILT_PAETH + 1, 255));
      end
      return 8'($urandom_range(pngu_pkg::FILT_NONE, pngu_pkg::FILT_PAETH));
    end
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_rows(input int unsigned n_rows, input int unsigned n_extra);
    int unsigned goal;
    goal = sb.rows_done + n_rows;
    while (sb.rows_done < goal) drive_byte(pick_byte());
    repeat (n_extra) drive_byte(pick_byte());
  endtask

  task automatic send_edge_row(input logic [7:0] filt_code, input int unsigned shift);
    int unsigned k;
    k = shift;
    drive_byte(filt_code);
    do begin
      drive_byte(extreme_vals[k % 6]);
      k++;
    end while (sb.col_idx != 0);
  endtask

  initial begin
    int unsigned start_bytes;
    int unsigned phase;
    logic [12:0] len_val;
    logic [15:0] rows_val;
    int unsigned n_rows;
    int unsigned n_extra;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset configuration first, then a too-short row length over several rows.
    send_edge_row(pngu_pkg::FILT_NONE, 0);
    settle();
    program_regs(13'd2, 16'd5);
    send_edge_row(pngu_pkg::FILT_SUB, 1);
    send_edge_row(pngu_pkg::FILT_UP, 2);
    send_edge_row(pngu_pkg::FILT_AVG, 3);
    send_edge_row(pngu_pkg::FILT_PAETH, 4);
    send_edge_row(8'hFF, 5);
    settle();

    start_bytes = sb.n_bytes;
    phase = 0;
    while (sb.n_bytes - start_bytes < RANDOM_BYTES) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0: len_val = 13'($urandom_range(0, 2));
          1: begin
            case ($urandom_range(0, 3))
              0: len_val = 13'd4096;
              1: len_val = 13'h1FFF;
              2: len_val = 13'd4095;
              default: len_val = 13'($urandom_range(4097, 8191));
            endcase
          end
          default: len_val = 13'($urandom_range(3, 30));
        endcase
        if (sb.row_idx != 0 && len_val > sb.line_fill) len_val = 13'(sb.line_fill);
        case ($urandom_range(0, 9))
          0: rows_val = 16'd0;
          1: rows_val = 16'hFFFF;
          2: rows_val = 16'd1;
          default: rows_val = 16'($urandom_range(2, 6));
        endcase
        program_regs(len_val, rows_val);
      end
      if (sb.eff_row_len() > 60) begin
        n_rows = 0;
        n_extra = $urandom_range(5, 60);
      end else begin
        n_rows = $urandom_range(1, 10);
        n_extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sb.eff_row_len()) : 0;
      end
      send_rows(n_rows, n_extra);
      settle();
      phase++;
    end

    $display("Run covered %0d stream bytes, %0d checked results, %0d rows, %0d images.",
             sb.n_bytes, sb.n_checked, sb.rows_done, sb.images_done);
    $display("Rows by filter: none %0d, sub %0d, up %0d, average %0d, paeth %0d, other %0d.",
             sb.rows_by_filter[pngu_pkg::FILT_NONE], sb.rows_by_filter[pngu_pkg::FILT_SUB],
             sb.rows_by_filter[pngu_pkg::FILT_UP], sb.rows_by_filter[pngu_pkg::FILT_AVG],
             sb.rows_by_filter[pngu_pkg::FILT_PAETH], sb.unknown_filter_rows);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
